// ===== design/matrix_keypad_scanner_debounce_top_defines.svh =====
// Assertion macros shared by the keypad scanner RTL.
`ifndef MATRIX_KEYPAD_SCANNER_DEBOUNCE_TOP_DEFINES_SVH
`define MATRIX_KEYPAD_SCANNER_DEBOUNCE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define MKP_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keypad scanner: same-cycle check failed");
// next-cycle implication
`define MKP_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keypad scanner: next-cycle check failed");
`else
`define MKP_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define MKP_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== design/mkp_pkg.sv =====
package mkp_pkg;

  // default geometry
  localparam int MKP_KEY_ROWS     = 4;
  localparam int MKP_KEY_COLS     = 4;
  localparam int MKP_BUFFER_DEPTH = 16;

  // results per read request, at most
  localparam int EMIT_MAX = 16;
  // keys visible in the snapshot
  localparam int SNAP_W   = 16;

  // request codes
  localparam logic [1:0] REQ_KEY_IRQ = 2'd0;
  localparam logic [1:0] REQ_TIMER   = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;

  // timer restart codes
  localparam logic [1:0] TR_NONE     = 2'd0;
  localparam logic [1:0] TR_DEBOUNCE = 2'd1;
  localparam logic [1:0] TR_SCAN     = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_HOLD_TIMEOUT    = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE_PASSES = 2'd1;

  localparam logic [7:0] HOLD_TIMEOUT_RST    = 8'd10;
  localparam logic [7:0] DEBOUNCE_PASSES_RST = 8'd2;

  typedef logic [7:0] key_code_t;

  // character codes, indexed [sense][drive]
  localparam key_code_t CODE_TABLE [4][4] = '{
    '{8'h31, 8'h32, 8'h33, 8'h41},   // 1 2 3 A
    '{8'h34, 8'h35, 8'h36, 8'h42},   // 4 5 6 B
    '{8'h37, 8'h38, 8'h39, 8'h43},   // 7 8 9 C
    '{8'h2A, 8'h30, 8'h23, 8'h44}    // * 0 # D
  };

  // code of the key at drive line d, sense line s; zero off the table
  function automatic key_code_t key_code_of(input int d, input int s);
    key_code_t c;
    c = 8'h00;
    if (d < 4 && s < 4) begin
      c = CODE_TABLE[s][d];
    end
    return c;
  endfunction

endpackage

// ===== design/mkp_scan.sv =====
// Matrix scan: compacts pressed keys into buffer slots after key_count.
module mkp_scan import mkp_pkg::*; #(
  parameter int KEY_ROWS     = MKP_KEY_ROWS,
  parameter int KEY_COLS     = MKP_KEY_COLS,
  parameter int BUFFER_DEPTH = MKP_BUFFER_DEPTH,
  localparam int EMIT_N = (BUFFER_DEPTH < EMIT_MAX) ? BUFFER_DEPTH : EMIT_MAX,
  localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1)
) (
  input  logic [SNAP_W-1:0] key_state,
  input  logic [CNT_W-1:0]  key_count,
  output logic [EMIT_N-1:0] wr_en,
  output key_code_t         wr_code [EMIT_N],
  output logic [CNT_W-1:0]  count_next,
  output logic              pushed
);

  // keys that can ever be seen
  localparam int NK_ALL = KEY_ROWS * KEY_COLS;
  localparam int NK     = (NK_ALL < SNAP_W) ? NK_ALL : SNAP_W;
  localparam int PCNT_W = $clog2(NK + 1);
  localparam int SUM_W  = $clog2(BUFFER_DEPTH + NK + 1);

  logic [NK-1:0]     pressed;
  key_code_t         bit_code [NK];
  logic [SUM_W-1:0]  pos      [NK];
  logic [PCNT_W-1:0] pcnt;
  logic [SUM_W-1:0]  total;

  assign pressed = key_state[NK-1:0];

  // per-key code and slot position
  for (genvar b = 0; b < NK; b++) begin : g_key
    localparam key_code_t CODE = key_code_of(b / KEY_COLS, b % KEY_COLS);
    localparam logic [NK-1:0] LOW_MASK = {NK{1'b1}} >> (NK - b);
    assign bit_code[b] = CODE;
    assign pos[b] = SUM_W'(key_count) + SUM_W'($countones(pressed & LOW_MASK));
  end

  // slot write selection; at most one key lands in a slot
  always_comb begin
    for (int j = 0; j < EMIT_N; j++) begin
      wr_en[j]   = 1'b0;
      wr_code[j] = 8'h00;
      for (int b = 0; b < NK; b++) begin
        if (pressed[b] && pos[b] == SUM_W'(j)) begin
          wr_en[j]   = 1'b1;
          wr_code[j] = wr_code[j] | bit_code[b];
        end
      end
    end
  end

  // new fill level, saturating at the buffer depth
  assign pcnt   = PCNT_W'($countones(pressed));
  assign total  = SUM_W'(key_count) + SUM_W'(pcnt);
  assign pushed = (pcnt != '0) && (key_count < CNT_W'(BUFFER_DEPTH));
  assign count_next = (total > SUM_W'(BUFFER_DEPTH)) ? CNT_W'(BUFFER_DEPTH)
                                                     : total[CNT_W-1:0];

endmodule

// ===== design/matrix_keypad_scanner_debounce_top.sv =====
// An accepted request passes the input register, then the result register, which drives the results.
// Throughput: one request per cycle for key interrupt and timer requests while out_stall is low; a read
//   request emits min(BUFFER_DEPTH,16) results, one per cycle unless out_stall is high, from the result register.
// Reset (rst, synchronous, active high): flags, counts and copy cleared,
//   hold_timeout 10, debounce_passes 2; key buffer contents left as they are.
`include "matrix_keypad_scanner_debounce_top_defines.svh"

module matrix_keypad_scanner_debounce_top import mkp_pkg::*; #(
  parameter int KEY_ROWS     = MKP_KEY_ROWS,
  parameter int KEY_COLS     = MKP_KEY_COLS,
  parameter int BUFFER_DEPTH = MKP_BUFFER_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [15:0] key_state,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  key_code,
  output logic        is_last,
  output logic [1:0]  timer_restart,
  output logic        key_down,
  output logic        data_ready,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int EMIT_N = (BUFFER_DEPTH < EMIT_MAX) ? BUFFER_DEPTH : EMIT_MAX;
  localparam int IDX_W  = (EMIT_N > 1) ? $clog2(EMIT_N) : 1;
  localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);

  // configuration registers
  logic [7:0] hold_timeout;
  logic [7:0] debounce_passes;

  // block state
  logic             debounce_active, debounce_active_next;
  logic             ready_flag, ready_flag_next;
  logic             keydown_flag, keydown_flag_next;
  logic [CNT_W-1:0] key_count, key_count_next;
  logic [7:0]       hold_count, hold_count_next;
  logic [7:0]       debounce_count, debounce_count_next;
  key_code_t        key_buffer [EMIT_N];
  key_code_t        copy_buffer [EMIT_N];
  key_code_t        copy_buffer_next [EMIT_N];

  // input register
  logic        s1_valid;
  logic [1:0]  s1_req;
  logic [15:0] s1_snap;

  // result register
  logic             job_valid;
  logic             job_read;
  logic [IDX_W-1:0] job_idx;
  logic [1:0]       job_restart;
  logic             job_key_down;
  logic             job_ready;

  logic       out_take, job_done, slot_free, s1_advance, in_accept;
  logic       scan_en;
  logic [1:0] restart_next;

  // scan unit
  logic [EMIT_N-1:0] scan_wr_en;
  key_code_t         scan_wr_code [EMIT_N];
  logic [CNT_W-1:0]  scan_count_next;
  logic              scan_pushed;

  mkp_scan #(
    .KEY_ROWS     (KEY_ROWS),
    .KEY_COLS     (KEY_COLS),
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_scan (
    .key_state  (s1_snap),
    .key_count  (key_count),
    .wr_en      (scan_wr_en),
    .wr_code    (scan_wr_code),
    .count_next (scan_count_next),
    .pushed     (scan_pushed)
  );

  // handshake
  assign out_take   = job_valid && !out_stall;
  assign job_done   = out_take && is_last;
  assign slot_free  = !job_valid || job_done;
  assign s1_advance = s1_valid && slot_free;
  assign in_stall   = s1_valid && !slot_free;
  assign in_accept  = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;

  // result payload
  assign out_valid     = job_valid;
  assign key_code      = job_read ? copy_buffer[job_idx] : 8'h00;
  assign is_last       = !job_read || (job_idx == IDX_W'(EMIT_N - 1));
  assign timer_restart = job_restart;
  assign key_down      = job_key_down;
  assign data_ready    = job_ready;

  // a scan runs on a timer expiry once debounce passes are used up
  assign scan_en = s1_advance && (s1_req == REQ_TIMER) && !debounce_active &&
                   !(debounce_count < debounce_passes);

  // request processing
  always_comb begin
    debounce_active_next = debounce_active;
    ready_flag_next      = ready_flag;
    keydown_flag_next    = keydown_flag;
    key_count_next       = key_count;
    hold_count_next      = hold_count;
    debounce_count_next  = debounce_count;
    copy_buffer_next     = copy_buffer;
    restart_next         = TR_NONE;
    if (s1_advance) begin
      unique case (s1_req)
        REQ_KEY_IRQ: begin
          if (!debounce_active) begin
            hold_count_next      = 8'd0;
            keydown_flag_next    = 1'b1;
            debounce_active_next = 1'b1;
            restart_next         = TR_DEBOUNCE;
          end
        end
        REQ_TIMER: begin
          if (debounce_active) begin
            debounce_active_next = 1'b0;
            restart_next         = TR_DEBOUNCE;
          end else if (debounce_count < debounce_passes) begin
            debounce_count_next = debounce_count + 8'd1;
            restart_next        = TR_DEBOUNCE;
          end else begin
            debounce_count_next = 8'd0;
            // hold timeout clears the copy
            if (hold_count > hold_timeout) begin
              hold_count_next = 8'd0;
              for (int k = 0; k < EMIT_N; k++) begin
                copy_buffer_next[k] = 8'h00;
              end
            end else begin
              hold_count_next = hold_count + 8'd1;
            end
            key_count_next    = scan_count_next;
            ready_flag_next   = ready_flag | keydown_flag | scan_pushed;
            keydown_flag_next = 1'b0;
            restart_next      = TR_SCAN;
          end
        end
        REQ_READ: begin
          if (ready_flag) begin
            for (int k = 0; k < EMIT_N; k++) begin
              copy_buffer_next[k] = (CNT_W'(k) < key_count) ? key_buffer[k] : 8'h00;
            end
            key_count_next  = '0;
            ready_flag_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_timeout    <= HOLD_TIMEOUT_RST;
      debounce_passes <= DEBOUNCE_PASSES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HOLD_TIMEOUT:    hold_timeout    <= cfg_data;
        REG_DEBOUNCE_PASSES: debounce_passes <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // block state
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_active <= 1'b0;
      ready_flag      <= 1'b0;
      keydown_flag    <= 1'b0;
      key_count       <= '0;
      hold_count      <= 8'd0;
      debounce_count  <= 8'd0;
      for (int k = 0; k < EMIT_N; k++) begin
        copy_buffer[k] <= 8'h00;
      end
    end else begin
      debounce_active <= debounce_active_next;
      ready_flag      <= ready_flag_next;
      keydown_flag    <= keydown_flag_next;
      key_count       <= key_count_next;
      hold_count      <= hold_count_next;
      debounce_count  <= debounce_count_next;
      copy_buffer     <= copy_buffer_next;
    end
  end

  // key buffer slots, no reset
  always_ff @(posedge clk) begin
    for (int j = 0; j < EMIT_N; j++) begin
      if (scan_en && scan_wr_en[j]) begin
        key_buffer[j] <= scan_wr_code[j];
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req  <= req_type;
      s1_snap <= key_state;
    end
  end

  // result register and read sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      job_idx   <= '0;
    end else begin
      priority if (s1_advance) begin
        job_valid <= 1'b1;
        job_idx   <= '0;
      end else if (job_done) begin
        job_valid <= 1'b0;
      end else if (out_take) begin
        job_idx <= job_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      job_read     <= (s1_req == REQ_READ);
      job_restart  <= restart_next;
      job_key_down <= keydown_flag_next;
      job_ready    <= ready_flag_next;
    end
  end

  // checks
  `MKP_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, key_count <= CNT_W'(BUFFER_DEPTH))
  `MKP_ASSERT_IMPLY(a_single_idx, clk, rst, job_valid && !job_read, job_idx == '0)
  `MKP_ASSERT_NEXT(a_scan_clears_keydown, clk, rst, scan_en, !keydown_flag)
  `MKP_ASSERT_NEXT(a_read_empties, clk, rst, s1_advance && s1_req == REQ_READ, key_count == '0 && !ready_flag)
  `MKP_ASSERT_IMPLY(a_stall_needs_job, clk, rst, in_stall, job_valid && s1_valid)

endmodule
